/* hw/rtl/double_ended_queue_core_defines.svh */
// assertion macros used by the deque checker file
`ifndef DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, held off while reset is active
`define DEQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off while reset is active
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/deq_pkg.sv */
// types, codes and defaults shared by the deque core
package deq_pkg;

	localparam int unsigned DEPTH_DEF = 64;
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned KIND_W    = 3;
	localparam int unsigned STATUS_W  = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH_FRONT = 3'd0,
		KIND_PUSH_REAR  = 3'd1,
		KIND_POP_FRONT  = 3'd2,
		KIND_POP_REAR   = 3'd3,
		KIND_PEEK_FRONT = 3'd4,
		KIND_PEEK_REAR  = 3'd5
	} deq_kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} deq_status_t;

	typedef enum logic {
		S_IDLE,
		S_READ
	} deq_state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic load_read;
	} deq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic needs_read;
	} deq_stat_t;

endpackage

/* hw/rtl/deq_ctrl.sv */
// controller: handshake sequencing and output valid
module deq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  deq_pkg::deq_stat_t stat,
	output deq_pkg::deq_cmd_t  cmd
);
	import deq_pkg::*;

	deq_state_t state_q, state_nx;
	logic       out_valid_q;
	logic       accept;
	logic       load;

	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && stat.needs_read) state_nx = S_READ;
			end
			S_READ: begin
				state_nx = S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.accept    = 1'b0;
		cmd.load_read = 1'b0;
		load          = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd.accept = accept;
				load       = accept && !stat.needs_read;
			end
			S_READ: begin
				// slot was freed when the beat was taken
				cmd.load_read = 1'b1;
				load          = 1'b1;
			end
			default: begin
				cmd.accept = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* hw/rtl/deq_dpath.sv */
// datapath: entry memory, ring pointers and result registers
module deq_dpath #(
	parameter int unsigned DEPTH = deq_pkg::DEPTH_DEF,
	parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  deq_pkg::deq_cmd_t                 cmd,
	output deq_pkg::deq_stat_t                stat,
	input  logic [deq_pkg::KIND_W-1:0]        kind,
	input  logic signed [deq_pkg::WORD_W-1:0] value,
	output logic signed [deq_pkg::WORD_W-1:0] result_value,
	output logic [deq_pkg::STATUS_W-1:0]      status,
	output logic [CW-1:0]                     fill_count,
	output logic                              is_empty
);
	import deq_pkg::*;

	localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WORD_W-1:0] entry_q [DEPTH];
	logic [WORD_W-1:0] rd_data_q;
	logic [IW-1:0]     head_q, head_nx;
	logic [CW-1:0]     count_q, count_nx;
	logic [CW-1:0]     count_m1;
	logic [IW-1:0]     head_prev, head_next, tail_pos, last_pos;
	logic [IW-1:0]     wr_addr, rd_addr;
	logic              wr_en;
	logic              is_full, is_zero;
	deq_status_t       status_nx;
	logic [WORD_W-1:0] imm_value;

	logic signed [WORD_W-1:0] result_value_q;
	logic [STATUS_W-1:0]      status_q;
	logic [CW-1:0]            fill_q;
	logic                     empty_q;

	function automatic logic [IW-1:0] ring_wrap(input logic [IW:0] s);
		logic [IW:0] r;
		r = (s >= (IW+1)'(DEPTH)) ? s - (IW+1)'(DEPTH) : s;
		return r[IW-1:0];
	endfunction

	assign is_full   = (count_q == CW'(DEPTH));
	assign is_zero   = (count_q == '0);
	assign count_m1  = count_q - CW'(1);
	assign head_prev = (head_q == '0) ? IW'(DEPTH - 1) : head_q - IW'(1);
	assign head_next = (head_q == IW'(DEPTH - 1)) ? '0 : head_q + IW'(1);
	assign tail_pos  = ring_wrap((IW+1)'(head_q) + (IW+1)'(count_q));
	assign last_pos  = ring_wrap((IW+1)'(head_q) + (IW+1)'(count_m1));

	always_comb begin
		head_nx         = head_q;
		count_nx        = count_q;
		wr_en           = 1'b0;
		wr_addr         = tail_pos;
		rd_addr         = head_q;
		status_nx       = STATUS_OK;
		imm_value       = '0;
		stat.needs_read = 1'b0;
		case (kind)
			KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
				if (is_full) begin
					status_nx = STATUS_FULL;
				end else begin
					wr_en    = 1'b1;
					count_nx = count_q + CW'(1);
					if (kind == KIND_PUSH_FRONT) begin
						head_nx = head_prev;
						wr_addr = head_prev;
					end
				end
			end
			KIND_POP_FRONT, KIND_POP_REAR, KIND_PEEK_FRONT, KIND_PEEK_REAR: begin
				if (is_zero) begin
					status_nx = STATUS_EMPTY;
					imm_value = '1;
				end else begin
					stat.needs_read = 1'b1;
					if (kind == KIND_POP_REAR || kind == KIND_PEEK_REAR) begin
						rd_addr = last_pos;
					end
					if (kind == KIND_POP_FRONT) begin
						head_nx  = head_next;
						count_nx = count_m1;
					end else if (kind == KIND_POP_REAR) begin
						count_nx = count_m1;
					end
				end
			end
			default: begin
				// unused codes leave the queue alone
				status_nx = STATUS_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && wr_en) begin
			entry_q[wr_addr] <= value;
		end
		if (cmd.accept) begin
			rd_data_q <= entry_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.accept) begin
			head_q  <= head_nx;
			count_q <= count_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			result_value_q <= imm_value;
			status_q       <= status_nx;
			fill_q         <= count_nx;
			empty_q        <= (count_nx == '0);
		end else if (cmd.load_read) begin
			result_value_q <= rd_data_q;
		end
	end

	assign result_value = result_value_q;
	assign status       = status_q;
	assign fill_count   = fill_q;
	assign is_empty     = empty_q;

endmodule

/* hw/rtl/double_ended_queue_core.sv */
// Double-ended queue of signed 32-bit words held in a ring of DEPTH entries. Every input
// beat carries one operation (push, pop or peek at either end) and yields exactly one
// result beat with the word, a status, the fill count after the operation and an empty
// flag. Pushes, unused operation codes and any operation answered as empty or full go
// straight to the output register; a pop or peek that reads an entry also passes a read
// state, since the entry memory has a registered read port, and takes no beat meanwhile.
// The result waits there, so the next beat can be taken in the cycle the previous result
// is taken. Entry memory needs no clearing after reset: only pushed entries are read.
module double_ended_queue_core #(
	parameter int unsigned DEPTH = deq_pkg::DEPTH_DEF,
	parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [deq_pkg::KIND_W-1:0]        kind,
	input  logic signed [deq_pkg::WORD_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [deq_pkg::WORD_W-1:0] result_value,
	output logic [deq_pkg::STATUS_W-1:0]      status,
	output logic [CW-1:0]                     fill_count,
	output logic                              is_empty
);
	import deq_pkg::*;

	deq_cmd_t  cmd;
	deq_stat_t stat;

	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	deq_dpath #(
		.DEPTH (DEPTH),
		.CW    (CW)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.kind         (kind),
		.value        (value),
		.result_value (result_value),
		.status       (status),
		.fill_count   (fill_count),
		.is_empty     (is_empty)
	);

endmodule

/* hw/rtl/deq_checker.sv */
// port-level checks for the deque core, bound to the top level
`include "double_ended_queue_core_defines.svh"

module deq_checker #(
	parameter int unsigned DEPTH = deq_pkg::DEPTH_DEF,
	parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [deq_pkg::WORD_W-1:0] result_value,
	input logic [deq_pkg::STATUS_W-1:0]      status,
	input logic [CW-1:0]                     fill_count,
	input logic                              is_empty
);
	import deq_pkg::*;

	`DEQ_ASSERT_NOW(a_fill_bound, clk, arst_n, out_valid, fill_count <= CW'(DEPTH), "fill count above depth")

	`DEQ_ASSERT_NOW(a_empty_flag, clk, arst_n, out_valid, is_empty == (fill_count == '0), "empty flag disagrees with fill count")

	`DEQ_ASSERT_NOW(a_empty_answer, clk, arst_n, out_valid && status == STATUS_EMPTY, result_value == -1 && fill_count == '0, "empty answer malformed")

	`DEQ_ASSERT_NOW(a_full_answer, clk, arst_n, out_valid && status == STATUS_FULL, result_value == 0 && fill_count == CW'(DEPTH), "full answer malformed")

	`DEQ_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(result_value) && $stable(fill_count), "result beat changed while stalled")

endmodule

bind double_ended_queue_core deq_checker #(
	.DEPTH (DEPTH),
	.CW    (CW)
) u_deq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.result_value (result_value),
	.status       (status),
	.fill_count   (fill_count),
	.is_empty     (is_empty)
);
